// ----- hw/rtl/dsfm_pkg.sv -----
// Shared types and codes for the sound FIFO mixer.
`timescale 1ns / 1ps

package dsfm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 2;

    typedef enum logic [1:0] {
        FUNC_PUSH_A = 2'd0,
        FUNC_PUSH_B = 2'd1,
        FUNC_TIMER  = 2'd2,
        FUNC_SAMPLE = 2'd3
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VOLUME_A_FULL  = 3'd0,
        REG_VOLUME_B_FULL  = 3'd1,
        REG_PAN_A          = 3'd2,
        REG_PAN_B          = 3'd3,
        REG_TIMER_A_SELECT = 3'd4,
        REG_TIMER_B_SELECT = 3'd5,
        REG_MASTER_ENABLE  = 3'd6
    } cfg_reg_t;

    // Per-channel command, valid only in the cycle a request is accepted
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_cmd_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               sample_valid;
        logic               refill_a;
        logic               refill_b;
        logic [5:0]         level_a;
        logic [5:0]         level_b;
    } result_t;

endpackage

// ----- hw/rtl/dsfm_fifo.sv -----
// Byte ring FIFO for one sound channel with its held output sample.
`timescale 1ns / 1ps

module dsfm_fifo #(
    parameter int DEPTH        = 32,
    parameter int REFILL_LEVEL = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dsfm_pkg::fifo_cmd_t        cmd,
    input  logic [31:0]                word,
    output logic [7:0]                 held,
    output logic [$clog2(DEPTH+1)-1:0] level_next,
    output logic                       refill
);
    import dsfm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    logic [7:0]    store_reg [DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    held_reg, held_next;
    logic [CW-1:0] count_dec;
    logic [CW:0]   count_plus4;
    logic [3:0]    wr_en;
    logic [AW-1:0] wr_addr [4];
    logic [SW-1:0] slot;

    always_comb begin
        count_dec   = count_reg - CW'(1);
        count_plus4 = {1'b0, count_reg} + (CW+1)'(4);
        for (int i = 0; i < 4; i++) begin
            wr_en[i] = cmd.push &&
                       (({1'b0, count_reg} + (CW+1)'(i)) < (CW+1)'(DEPTH));
            slot = SW'(head_reg) + SW'(count_reg) + SW'(i);
            // slot stays below twice the depth whenever the byte is written
            if (slot >= SW'(DEPTH)) begin
                slot = slot - SW'(DEPTH);
            end
            wr_addr[i] = slot[AW-1:0];
        end
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        held_next  = held_reg;
        refill     = 1'b0;
        if (cmd.push) begin
            count_next = (count_plus4 > (CW+1)'(DEPTH)) ? CW'(DEPTH) : count_plus4[CW-1:0];
        end else if (cmd.pop) begin
            // empty FIFO: keep the held sample, raise no refill
            if (count_reg != '0) begin
                held_next  = store_reg[head_reg];
                head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                count_next = count_dec;
                refill     = (32'(count_dec) <= 32'(REFILL_LEVEL));
            end
        end else if (cmd.clear) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            held_reg  <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            if (wr_en[i]) begin
                store_reg[wr_addr[i]] <= word[8*i +: 8];
            end
        end
    end

    assign held       = held_reg;
    assign level_next = count_next;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("FIFO count beyond depth");

    a_refill_needs_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        refill |-> (cmd.pop && count_reg != '0 && !cmd.push))
        else $error("refill raised without a pop");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.clear && !cmd.push && !cmd.pop) |=> (count_reg == '0))
        else $error("clear left bytes queued");
`endif

endmodule

// ----- hw/rtl/dma_sound_fifo_mixer.sv -----
// Dual sound FIFO stereo mixer: top level with register file, mixing and output buffer.
`timescale 1ns / 1ps

// Takes one request per clock: a word push into FIFO A or B, a timer overflow that pops
// the channels tied to that timer, or a sample request that applies the clear strobes
// and mixes the two held samples into a 16-bit stereo pair. Every request produces one
// result, registered in the output register or the skid entry; all of the work (byte
// writes, pop, mixing with a shift-and-subtract scale) is combinational ahead of the
// output register. An output register plus one skid entry lets s_ready stay high while
// one result waits on m_ready, so the sustained rate is one request per cycle and
// s_ready drops only when two results are waiting.
module dma_sound_fifo_mixer #(
    parameter int FIFO_DEPTH   = 32,
    parameter int REFILL_LEVEL = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [dsfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dsfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_func,
    input  logic [31:0]                      s_word,
    input  logic [1:0]                       s_timer_index,
    input  logic                             s_clear_a,
    input  logic                             s_clear_b,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [15:0]               m_left_out,
    output logic signed [15:0]               m_right_out,
    output logic                             m_sample_valid,
    output logic                             m_refill_a,
    output logic                             m_refill_b,
    output logic [5:0]                       m_level_a,
    output logic [5:0]                       m_level_b
);
    import dsfm_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic       volume_a_full_reg, volume_b_full_reg;
    logic [1:0] pan_a_reg, pan_b_reg;
    logic       timer_a_select_reg, timer_b_select_reg;
    logic       master_enable_reg;

    logic          accept;
    fifo_cmd_t     cmd_a, cmd_b;
    logic [7:0]    held_a, held_b;
    logic [CW-1:0] level_a_next, level_b_next;
    logic          refill_a, refill_b;

    logic signed [9:0] base_a, base_b, contrib_a, contrib_b;
    logic signed [9:0] mix_left, mix_right;
    result_t           res;

    result_t main_reg, skid_reg;
    logic    main_valid_reg, skid_valid_reg;
    logic    take;

    // Clamp to +-256 (1/256 units), scale by 32767/256, round half away from zero
    function automatic logic signed [15:0] scale_out(input logic signed [9:0] sum);
        logic signed [9:0] clamped;
        logic [8:0]        mag;
        logic [23:0]       prod;
        logic [15:0]       q;
        if (sum > 10'sd256) begin
            clamped = 10'sd256;
        end else if (sum < -10'sd256) begin
            clamped = -10'sd256;
        end else begin
            clamped = sum;
        end
        mag  = clamped[9] ? 9'(-clamped) : 9'(clamped);
        prod = {mag, 15'b0} - 24'(mag);
        q    = 16'((prod + 24'd128) >> 8);
        return clamped[9] ? signed'(-q) : signed'(q);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_a_full_reg  <= 1'b0;
            volume_b_full_reg  <= 1'b0;
            pan_a_reg          <= 2'b00;
            pan_b_reg          <= 2'b00;
            timer_a_select_reg <= 1'b0;
            timer_b_select_reg <= 1'b0;
            master_enable_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_VOLUME_A_FULL:  volume_a_full_reg  <= cfg_wdata[0];
                REG_VOLUME_B_FULL:  volume_b_full_reg  <= cfg_wdata[0];
                REG_PAN_A:          pan_a_reg          <= cfg_wdata[1:0];
                REG_PAN_B:          pan_b_reg          <= cfg_wdata[1:0];
                REG_TIMER_A_SELECT: timer_a_select_reg <= cfg_wdata[0];
                REG_TIMER_B_SELECT: timer_b_select_reg <= cfg_wdata[0];
                REG_MASTER_ENABLE:  master_enable_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // Timer indexes two and three never match a one-bit select
    always_comb begin
        cmd_a.push  = accept && (s_func == FUNC_PUSH_A);
        cmd_b.push  = accept && (s_func == FUNC_PUSH_B);
        cmd_a.pop   = accept && (s_func == FUNC_TIMER) &&
                      (s_timer_index == {1'b0, timer_a_select_reg});
        cmd_b.pop   = accept && (s_func == FUNC_TIMER) &&
                      (s_timer_index == {1'b0, timer_b_select_reg});
        cmd_a.clear = accept && (s_func == FUNC_SAMPLE) && s_clear_a;
        cmd_b.clear = accept && (s_func == FUNC_SAMPLE) && s_clear_b;
    end

    dsfm_fifo #(
        .DEPTH        (FIFO_DEPTH),
        .REFILL_LEVEL (REFILL_LEVEL)
    ) u_fifo_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd_a),
        .word       (s_word),
        .held       (held_a),
        .level_next (level_a_next),
        .refill     (refill_a)
    );

    dsfm_fifo #(
        .DEPTH        (FIFO_DEPTH),
        .REFILL_LEVEL (REFILL_LEVEL)
    ) u_fifo_b (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd_b),
        .word       (s_word),
        .held       (held_b),
        .level_next (level_b_next),
        .refill     (refill_b)
    );

    always_comb begin
        base_a    = 10'(signed'(held_a));
        base_b    = 10'(signed'(held_b));
        contrib_a = volume_a_full_reg ? (base_a <<< 1) : base_a;
        contrib_b = volume_b_full_reg ? (base_b <<< 1) : base_b;
        mix_left  = (pan_a_reg[1] ? contrib_a : 10'sd0) + (pan_b_reg[1] ? contrib_b : 10'sd0);
        mix_right = (pan_a_reg[0] ? contrib_a : 10'sd0) + (pan_b_reg[0] ? contrib_b : 10'sd0);

        res.sample_valid = (s_func == FUNC_SAMPLE);
        res.left_out     = (res.sample_valid && master_enable_reg) ? scale_out(mix_left)
                                                                   : 16'sd0;
        res.right_out    = (res.sample_valid && master_enable_reg) ? scale_out(mix_right)
                                                                   : 16'sd0;
        res.refill_a     = refill_a;
        res.refill_b     = refill_b;
        res.level_a      = 6'(level_a_next);
        res.level_b      = 6'(level_b_next);
    end

    assign take = main_valid_reg && m_ready;

    // Output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= accept;
            end
        end else if (accept) begin
            if (main_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            main_reg <= skid_valid_reg ? skid_reg : res;
        end else if (accept) begin
            if (main_valid_reg) begin
                skid_reg <= res;
            end else begin
                main_reg <= res;
            end
        end
    end

    assign m_valid        = main_valid_reg;
    assign m_left_out     = main_reg.left_out;
    assign m_right_out    = main_reg.right_out;
    assign m_sample_valid = main_reg.sample_valid;
    assign m_refill_a     = main_reg.refill_a;
    assign m_refill_b     = main_reg.refill_b;
    assign m_level_a      = main_reg.level_a;
    assign m_level_b      = main_reg.level_b;

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");

    a_mix_only_on_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && !main_reg.sample_valid) |->
            (main_reg.left_out == 16'sd0 && main_reg.right_out == 16'sd0))
        else $error("non-sample result carries mixed audio");

    a_no_refill_on_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && main_reg.sample_valid) |->
            (!main_reg.refill_a && !main_reg.refill_b))
        else $error("refill reported on a sample result");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the dual sound FIFO stereo mixer.
`timescale 1ns / 1ps

module testbench;
    import dsfm_pkg::*;

    localparam int FIFO_BYTES  = 32;
    localparam int REFILL_MARK = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 142;

    typedef struct packed {
        func_t       func;
        logic [31:0] word;
        logic [1:0]  timer_index;
        logic        clear_a;
        logic        clear_b;
    } mix_request_t;

    typedef struct packed {
        logic       volume_a_full;
        logic       volume_b_full;
        logic [1:0] pan_a;
        logic [1:0] pan_b;
        logic       timer_a_select;
        logic       timer_b_select;
        logic       master_enable;
    } mixer_setting_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = '0;
    logic [31:0] s_word = '0;
    logic [1:0] s_timer_index = '0;
    logic s_clear_a = 1'b0;
    logic s_clear_b = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_left_out;
    logic signed [15:0] m_right_out;
    logic m_sample_valid;
    logic m_refill_a;
    logic m_refill_b;
    logic [5:0] m_level_a;
    logic [5:0] m_level_b;

    dma_sound_fifo_mixer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_word         (s_word),
        .s_timer_index  (s_timer_index),
        .s_clear_a      (s_clear_a),
        .s_clear_b      (s_clear_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .m_sample_valid (m_sample_valid),
        .m_refill_a     (m_refill_a),
        .m_refill_b     (m_refill_b),
        .m_level_a      (m_level_a),
        .m_level_b      (m_level_b)
    );

    always #6 aclk = ~aclk;

    // Shadow of the mixer: channel 0 is A, channel 1 is B
    logic [7:0] fifo_mem [2][FIFO_BYTES];
    int         fifo_head [2];
    int         fifo_count [2];
    logic [7:0] fifo_held [2];
    logic       vol_full [2];
    logic [1:0] pan_bits [2];
    logic       timer_sel [2];
    logic       master_on;

    mix_request_t pending_requests [$];
    result_t      expected_results [$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   hold_requests = 0;
    int   holds_served = 0;
    int   rx_hold_left = 0;
    logic s_taken = 1'b0;

    function automatic void push_word(int ch, logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            if (fifo_count[ch] < FIFO_BYTES) begin
                fifo_mem[ch][(fifo_head[ch] + fifo_count[ch]) % FIFO_BYTES] = w[8*i +: 8];
                fifo_count[ch]++;
            end
        end
    endfunction

    function automatic logic pop_byte(int ch);
        if (fifo_count[ch] == 0)
            return 1'b0;
        fifo_held[ch] = fifo_mem[ch][fifo_head[ch]];
        fifo_head[ch] = (fifo_head[ch] + 1) % FIFO_BYTES;
        fifo_count[ch]--;
        return fifo_count[ch] <= REFILL_MARK;
    endfunction

    // Sum in 1/256 units to a 16-bit sample, rounded half away from zero
    function automatic logic signed [15:0] scale_sample(int sum);
        int mag;
        int q;
        if (sum > 256) sum = 256;
        if (sum < -256) sum = -256;
        mag = ((sum < 0) ? -sum : sum) * 32767;
        q = (mag + 128) >>> 8;
        return (sum < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic result_t predict_mix(mix_request_t r);
        result_t res;
        int contrib [2];
        int mix_l;
        int mix_r;
        int h;
        res = '0;
        case (r.func)
            FUNC_PUSH_A: push_word(0, r.word);
            FUNC_PUSH_B: push_word(1, r.word);
            FUNC_TIMER: begin
                if (r.timer_index == {1'b0, timer_sel[0]}) res.refill_a = pop_byte(0);
                if (r.timer_index == {1'b0, timer_sel[1]}) res.refill_b = pop_byte(1);
            end
            default: begin
                res.sample_valid = 1'b1;
                if (r.clear_a) fifo_count[0] = 0;
                if (r.clear_b) fifo_count[1] = 0;
                if (master_on) begin
                    mix_l = 0;
                    mix_r = 0;
                    for (int ch = 0; ch < 2; ch++) begin
                        h = fifo_held[ch];
                        if (h > 127) h -= 256;
                        contrib[ch] = h * (vol_full[ch] ? 2 : 1);
                        if (pan_bits[ch][1]) mix_l += contrib[ch];
                        if (pan_bits[ch][0]) mix_r += contrib[ch];
                    end
                    res.left_out = scale_sample(mix_l);
                    res.right_out = scale_sample(mix_r);
                end
            end
        endcase
        res.level_a = 6'(fifo_count[0]);
        res.level_b = 6'(fifo_count[1]);
        return res;
    endfunction

    task automatic check_field(string field, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Monitor: check delivered results, predict accepted requests
    always @(posedge aclk) begin : monitor
        result_t want;
        mix_request_t req;
        if (aresetn) begin
            if (m_valid === 1'b1 && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result mismatch, expected none, got left %0d right %0d",
                             $time, m_left_out, m_right_out);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("left_out", want.left_out, m_left_out);
                    check_field("right_out", want.right_out, m_right_out);
                    check_field("sample_valid", want.sample_valid, m_sample_valid);
                    check_field("refill_a", want.refill_a, m_refill_a);
                    check_field("refill_b", want.refill_b, m_refill_b);
                    check_field("level_a", want.level_a, m_level_a);
                    check_field("level_b", want.level_b, m_level_b);
                end
            end
            if (s_valid && s_ready === 1'b1) begin
                req.func = func_t'(s_func);
                req.word = s_word;
                req.timer_index = s_timer_index;
                req.clear_a = s_clear_a;
                req.clear_b = s_clear_b;
                expected_results = {expected_results, predict_mix(req)};
            end
        end
        s_taken <= s_valid && s_ready === 1'b1;
    end

    // Driver: hold a request until taken, then offer the next one or idle
    always @(negedge aclk) begin : driver
        mix_request_t nxt;
        if (aresetn && (!s_valid || s_taken)) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                nxt = pending_requests.pop_front();
                s_valid <= 1'b1;
                s_func <= nxt.func;
                s_word <= nxt.word;
                s_timer_index <= nxt.timer_index;
                s_clear_a <= nxt.clear_a;
                s_clear_b <= nxt.clear_b;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus an occasional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (hold_requests != holds_served) begin
            m_ready <= 1'b0;
            rx_hold_left <= 400;
            holds_served <= holds_served + 1;
        end else begin
            m_ready <= $urandom_range(0, 99) >= rx_idle_pct;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic mix_request_t make_request(func_t f, logic [31:0] w, logic [1:0] t,
                                                  logic ca, logic cb);
        mix_request_t r;
        r.func = f;
        r.word = w;
        r.timer_index = t;
        r.clear_a = ca;
        r.clear_b = cb;
        return r;
    endfunction

    // Append a request to the driver's queue
    function automatic void queue_request(mix_request_t r);
        pending_requests = {pending_requests, r};
    endfunction

    function automatic mix_request_t random_request(int push_pct);
        mix_request_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < push_pct / 2)
            r.func = FUNC_PUSH_A;
        else if (pick < push_pct)
            r.func = FUNC_PUSH_B;
        else if (pick < push_pct + (100 - push_pct) * 2 / 3)
            r.func = FUNC_TIMER;
        else
            r.func = FUNC_SAMPLE;
        case ($urandom_range(0, 9))
            0: r.word = 32'h80808080;
            1: r.word = 32'h7F7F7F7F;
            default: r.word = $urandom();
        endcase
        if ($urandom_range(0, 4) == 0)
            r.timer_index = 2'($urandom_range(0, 3));
        else
            r.timer_index = {1'b0, timer_sel[$urandom_range(0, 1)]};
        r.clear_a = $urandom_range(0, 9) == 0;
        r.clear_b = $urandom_range(0, 9) == 0;
        return r;
    endfunction

    task automatic write_setting(cfg_reg_t idx, logic [1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_VOLUME_A_FULL:  vol_full[0] = val[0];
            REG_VOLUME_B_FULL:  vol_full[1] = val[0];
            REG_PAN_A:          pan_bits[0] = val;
            REG_PAN_B:          pan_bits[1] = val;
            REG_TIMER_A_SELECT: timer_sel[0] = val[0];
            REG_TIMER_B_SELECT: timer_sel[1] = val[0];
            REG_MASTER_ENABLE:  master_on = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setting(mixer_setting_t s);
        write_setting(REG_VOLUME_A_FULL, {1'b0, s.volume_a_full});
        write_setting(REG_VOLUME_B_FULL, {1'b0, s.volume_b_full});
        write_setting(REG_PAN_A, s.pan_a);
        write_setting(REG_PAN_B, s.pan_b);
        write_setting(REG_TIMER_A_SELECT, {1'b0, s.timer_a_select});
        write_setting(REG_TIMER_B_SELECT, {1'b0, s.timer_b_select});
        write_setting(REG_MASTER_ENABLE, {1'b0, s.master_enable});
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        mixer_setting_t setting;
        int push_pct;
        for (int ch = 0; ch < 2; ch++) begin
            fifo_head[ch] = 0;
            fifo_count[ch] = 0;
            fifo_held[ch] = '0;
            vol_full[ch] = 1'b0;
            pan_bits[ch] = '0;
            timer_sel[ch] = 1'b0;
        end
        master_on = 1'b0;
        tx_idle_pct = 28;
        rx_idle_pct = 71;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: full volume, both pans, both channels on timer 0
        load_setting('{1'b1, 1'b1, 2'd3, 2'd3, 1'b0, 1'b0, 1'b1});
        queue_request(make_request(FUNC_SAMPLE, 32'h0, 2'd0, 1'b0, 1'b0));
        // pop with both FIFOs empty keeps the held values
        queue_request(make_request(FUNC_TIMER, 32'h0, 2'd0, 1'b0, 1'b0));
        queue_request(make_request(FUNC_PUSH_A, 32'h7F808080, 2'd0, 1'b0, 1'b0));
        queue_request(make_request(FUNC_PUSH_B, 32'h7F808080, 2'd0, 1'b0, 1'b0));
        queue_request(make_request(FUNC_TIMER, 32'h0, 2'd0, 1'b0, 1'b0));
        // negative full scale on both sides clamps low
        queue_request(make_request(FUNC_SAMPLE, 32'h0, 2'd0, 1'b0, 1'b0));
        queue_request(make_request(FUNC_TIMER, 32'h0, 2'd1, 1'b0, 1'b0));
        queue_request(make_request(FUNC_TIMER, 32'h0, 2'd2, 1'b0, 1'b0));
        queue_request(make_request(FUNC_TIMER, 32'h0, 2'd3, 1'b0, 1'b0));
        repeat (3)
            queue_request(make_request(FUNC_TIMER, 32'h0, 2'd0, 1'b0, 1'b0));
        // positive full scale clamps high
        queue_request(make_request(FUNC_SAMPLE, 32'h0, 2'd0, 1'b0, 1'b0));
        repeat (8)
            queue_request(make_request(FUNC_PUSH_A, 32'hFFFFFFFF, 2'd3, 1'b1, 1'b1));
        // FIFO A is full: drop the whole word
        queue_request(make_request(FUNC_PUSH_A, 32'h0, 2'd0, 1'b0, 1'b0));
        // clear strobes outside a sample request do nothing
        queue_request(make_request(FUNC_PUSH_B, 32'h0, 2'd0, 1'b1, 1'b1));
        queue_request(make_request(FUNC_TIMER, 32'h0, 2'd0, 1'b0, 1'b0));
        queue_request(make_request(FUNC_SAMPLE, 32'h0, 2'd0, 1'b1, 1'b0));
        queue_request(make_request(FUNC_SAMPLE, 32'h0, 2'd0, 1'b0, 1'b1));
        queue_request(make_request(FUNC_TIMER, 32'h0, 2'd0, 1'b0, 1'b0));
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                tx_idle_pct = 28;
                rx_idle_pct = 71;
            end else if (phase < 6) begin
                tx_idle_pct = 71;
                rx_idle_pct = 28;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (phase == 1)
                setting = '0;
            else if (phase == 4)
                setting = '{1'b1, 1'b1, 2'd3, 2'd3, 1'b1, 1'b1, 1'b1};
            else begin
                setting = mixer_setting_t'(9'($urandom()));
                setting.master_enable = $urandom_range(0, 4) != 0;
            end
            load_setting(setting);
            push_pct = 30;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // vary the fill rate in bursts so the levels sweep the full range
                if (i % 16 == 0)
                    push_pct = $urandom_range(5, 55);
                queue_request(random_request(push_pct));
            end
            if (phase == 6)
                hold_requests++;
            wait_drained();
        end

        repeat (8) @(negedge aclk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- dma_sound_fifo_mixer.f -----
hw/rtl/dsfm_pkg.sv
hw/rtl/dsfm_fifo.sv
hw/rtl/dma_sound_fifo_mixer.sv
verif/testbench.sv
